// ===== rtl/ocu_pkg.sv =====
// ----------------------------------------------------------------------------
// Orbit camera update package
// Shared widths, constants, operation codes, payload types and helpers.
// ----------------------------------------------------------------------------
package ocu_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int ANG_BITS     = 30;
   localparam int Q_SHIFT      = ANG_BITS - FRAC_BITS;
   // Angle word: a full 32-bit amount scaled to angle format, plus headroom.
   localparam int ANG_W        = 32 + Q_SHIFT + 2;
   // Quotient bits needed to reduce an angle word modulo two pi.
   localparam int WRAP_STEPS   = ANG_W - 33;
   localparam int WK_W         = $clog2(WRAP_STEPS);
   localparam int CW           = 40;
   localparam int STEP_W       = 5;
   localparam int MA_W         = 42;
   localparam int MB_W         = 34;
   localparam int MO_W         = 44;

   localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(64'sd3373259426);
   localparam logic signed [ANG_W-1:0] HALF_PI_A = ANG_W'(64'sd1686629713);
   localparam logic signed [ANG_W-1:0] TWO_PI_A  = ANG_W'(64'sd6746518852);
   localparam logic signed [CW-1:0]    KINV_A    = CW'(64'sd652032874);

   localparam logic [2:0] OP_SET_VIEW = 3'd0;
   localparam logic [2:0] OP_MOVE     = 3'd1;
   localparam logic [2:0] OP_ROT_EL   = 3'd2;
   localparam logic [2:0] OP_ROT_AZ   = 3'd3;
   localparam logic [2:0] OP_ZOOM     = 3'd4;

   typedef struct packed {
      logic [2:0]         operation;
      logic               absolute;
      logic signed [31:0] amount;
      logic signed [31:0] vec_a_x;
      logic signed [31:0] vec_a_y;
      logic signed [31:0] vec_a_z;
      logic signed [31:0] vec_b_x;
      logic signed [31:0] vec_b_y;
      logic signed [31:0] vec_b_z;
      logic signed [31:0] vec_c_x;
      logic signed [31:0] vec_c_y;
      logic signed [31:0] vec_c_z;
   } ocu_req_type;

   typedef struct packed {
      logic signed [31:0] eye_out_x;
      logic signed [31:0] eye_out_y;
      logic signed [31:0] eye_out_z;
      logic signed [31:0] target_out_x;
      logic signed [31:0] target_out_y;
      logic signed [31:0] target_out_z;
      logic signed [31:0] up_out_x;
      logic signed [31:0] up_out_y;
      logic signed [31:0] up_out_z;
      logic [30:0]        distance_out;
   } ocu_rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ocu_unit_status_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_VEC_A, ST_MAG_A, ST_VEC_B, ST_MAG_B, ST_APPLY,
      ST_WRAP_AZ, ST_ROT_AZ, ST_WRAP_EL, ST_ROT_EL,
      ST_MUL_RAD, ST_MUL_EX, ST_MUL_EY, ST_MUL_EZ, ST_MUL_UX, ST_MUL_UY,
      ST_UPDATE, ST_FINISH
   } ocu_state_type;

   function automatic logic [31:0] atan_entry(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0:    r = 32'h3243F6A8;
         5'd1:    r = 32'h1DAC6705;
         5'd2:    r = 32'h0FADBAFC;
         5'd3:    r = 32'h07F56EA6;
         5'd4:    r = 32'h03FEAB76;
         5'd5:    r = 32'h01FFD55B;
         5'd6:    r = 32'h00FFFAAA;
         5'd7:    r = 32'h007FFF55;
         5'd8:    r = 32'h003FFFEA;
         5'd9:    r = 32'h001FFFFD;
         5'd10:   r = 32'h000FFFFF;
         5'd11:   r = 32'h0007FFFF;
         5'd12:   r = 32'h0003FFFF;
         5'd13:   r = 32'h0001FFFF;
         5'd14:   r = 32'h0000FFFF;
         5'd15:   r = 32'h00007FFF;
         5'd16:   r = 32'h00003FFF;
         5'd17:   r = 32'h00001FFF;
         5'd18:   r = 32'h00000FFF;
         5'd19:   r = 32'h000007FF;
         5'd20:   r = 32'h000003FF;
         5'd21:   r = 32'h000001FF;
         5'd22:   r = 32'h000000FF;
         5'd23:   r = 32'h0000007F;
         5'd24:   r = 32'h0000003F;
         5'd25:   r = 32'h0000001F;
         5'd26:   r = 32'h0000000F;
         5'd27:   r = 32'h00000008;
         5'd28:   r = 32'h00000004;
         5'd29:   r = 32'h00000002;
         5'd30:   r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [MO_W:0] v);
      logic signed [31:0] r;
      if (v > (MO_W+1)'(64'sd2147483647)) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -(MO_W+1)'(64'sd2147483648)) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Angle-format value to position format, rounding toward minus infinity.
   function automatic logic signed [31:0] to_q(input logic signed [MO_W-1:0] v);
      logic signed [MO_W-1:0] s;
      s = v >>> Q_SHIFT;
      return sat32((MO_W+1)'(s));
   endfunction

endpackage

// ===== rtl/ocu_cordic.sv =====
// ----------------------------------------------------------------------------
// Orbit camera CORDIC unit
// One shift-add iteration per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ocu_cordic import ocu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    rotate,
   input  logic                    neg,
   input  logic signed [CW-1:0]    x0,
   input  logic signed [CW-1:0]    y0,
   input  logic signed [ANG_W-1:0] z0,
   output logic signed [CW-1:0]    x_out,
   output logic signed [CW-1:0]    y_out,
   output logic signed [ANG_W-1:0] z_out,
   output ocu_unit_status_type     status
);

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   logic signed [CW-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0] z_ff, z_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic                    neg_ff, neg_in, rot_ff, rot_in;
   logic signed [CW-1:0]    dx, dy;
   logic signed [ANG_W-1:0] atan_v;
   logic                    turn_down;

   assign dx        = y_ff >>> step_ff;
   assign dy        = x_ff >>> step_ff;
   assign atan_v    = $signed({{(ANG_W-32){1'b0}}, atan_entry(step_ff)});
   assign turn_down = rot_ff ? !z_ff[ANG_W-1] : y_ff[CW-1];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      rot_in  = rot_ff;
      if (start && !busy_ff) begin
         neg_in  = rotate & neg;
         rot_in  = rotate;
         step_in = '0;
         busy_in = 1'b1;
         if (rotate) begin
            x_in = KINV_A;
            y_in = '0;
            z_in = z0;
         end else if (x0 == '0 && y0 == '0) begin
            // A zero vector has no angle: report zero at once.
            x_in    = '0;
            y_in    = '0;
            z_in    = '0;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (x0 < 0) begin
            x_in = -x0;
            y_in = -y0;
            z_in = (y0 >= 0) ? PI_A : -PI_A;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (turn_down) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - atan_v;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + atan_v;
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      rot_ff  <= rot_in;
   end

   assign x_out       = neg_ff ? -x_ff : x_ff;
   assign y_out       = neg_ff ? -y_ff : y_ff;
   assign z_out       = z_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/ocu_wrap.sv =====
// ----------------------------------------------------------------------------
// Orbit camera angle reduction
// Restoring reduction modulo two pi, then a fold into plus or minus half pi.
// ----------------------------------------------------------------------------
module ocu_wrap import ocu_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ANG_W-1:0] angle,
   output logic signed [ANG_W-1:0] z_out,
   output logic                    neg_out,
   output ocu_unit_status_type     status
);

   localparam logic [ANG_W-1:0] TWO_PI_U = ANG_W'(TWO_PI_A);

   logic [ANG_W-1:0]        mag_ff, mag_in;
   logic                    sign_ff, sign_in;
   logic [WK_W-1:0]         k_ff, k_in;
   logic                    busy_ff, busy_in, done_ff, done_in;
   logic [ANG_W-1:0]        cand;
   logic signed [ANG_W-1:0] z_rem, z_half;

   assign cand = TWO_PI_U << k_ff;

   always_comb begin
      mag_in  = mag_ff;
      sign_in = sign_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         sign_in = angle[ANG_W-1];
         mag_in  = angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
         k_in    = WK_W'(WRAP_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mag_ff >= cand) begin
            mag_in = mag_ff - cand;
         end
         if (k_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            k_in = k_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_ff  <= mag_in;
      sign_ff <= sign_in;
      k_ff    <= k_in;
   end

   // The remainder keeps the sign of the angle, as a truncating modulo does.
   always_comb begin
      z_rem = sign_ff ? -$signed(mag_ff) : $signed(mag_ff);
      if (z_rem > PI_A) begin
         z_half = z_rem - TWO_PI_A;
      end else if (z_rem < -PI_A) begin
         z_half = z_rem + TWO_PI_A;
      end else begin
         z_half = z_rem;
      end
      neg_out = 1'b0;
      z_out   = z_half;
      if (z_half > HALF_PI_A) begin
         z_out   = z_half - PI_A;
         neg_out = 1'b1;
      end else if (z_half < -HALF_PI_A) begin
         z_out   = z_half + PI_A;
         neg_out = 1'b1;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/ocu_mul.sv =====
// ----------------------------------------------------------------------------
// Orbit camera fixed-point multiplier
// Sign-magnitude product scaled by 2^-30, truncated toward zero, in two
// partial products.
// ----------------------------------------------------------------------------
module ocu_mul import ocu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic signed [MA_W-1:0] a,
   input  logic signed [MB_W-1:0] b,
   output logic signed [MO_W-1:0] p,
   output ocu_unit_status_type    status
);

   localparam int LO_W   = 20;
   localparam int HI_W   = MA_W - LO_W;
   localparam int PROD_W = HI_W + MB_W;
   localparam int ACC_W  = MA_W + MB_W;

   logic [MA_W-1:0]   ua_ff, ua_in;
   logic [MB_W-1:0]   ub_ff, ub_in;
   logic              negp_ff, negp_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [1:0]        phase_ff, phase_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [ACC_W-ANG_BITS-1:0] mag;

   always_comb begin
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      negp_in  = negp_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start && !busy_ff) begin
         ua_in    = a[MA_W-1] ? MA_W'(-a) : MA_W'(a);
         ub_in    = b[MB_W-1] ? MB_W'(-b) : MB_W'(b);
         negp_in  = a[MA_W-1] ^ b[MB_W-1];
         phase_in = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         case (phase_ff)
            2'd0: begin
               prod_in  = PROD_W'(ua_ff[LO_W-1:0]) * PROD_W'(ub_ff);
               phase_in = 2'd1;
            end
            2'd1: begin
               acc_in   = ACC_W'(prod_ff);
               prod_in  = PROD_W'(ua_ff[MA_W-1:LO_W]) * PROD_W'(ub_ff);
               phase_in = 2'd2;
            end
            default: begin
               acc_in  = acc_ff + (ACC_W'(prod_ff) << LO_W);
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      ua_ff    <= ua_in;
      ub_ff    <= ub_in;
      negp_ff  <= negp_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      phase_ff <= phase_in;
   end

   assign mag         = acc_ff[ACC_W-1:ANG_BITS];
   assign p           = negp_ff ? -$signed(MO_W'(mag)) : $signed(MO_W'(mag));
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/orbit_camera_update_unit.sv =====
// ----------------------------------------------------------------------------
// Orbit camera update unit
// Set view, move and unused codes use the shared CORDIC unit for two passes
// and the multiplier twice; rotate and zoom use six CORDIC passes, two angle
// reductions and ten multiplies. One transfer at a time: a new transfer is
// taken only back in idle, after the result is registered, and the result
// waits while a previous result is still stalled.
// Synchronous reset clears the camera vectors and all control state.
// ----------------------------------------------------------------------------
module orbit_camera_update_unit import ocu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  ocu_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ocu_rsp_type rsp_data
);

   ocu_state_type state_ff, state_in;
   logic          launched_ff, launched_in;
   logic          final_ff, final_in;
   logic          rsp_valid_ff, rsp_valid_in;
   ocu_rsp_type   rsp_ff, rsp_in;
   ocu_req_type   req_ff, req_in;

   logic signed [31:0] eye_ff [3];
   logic signed [31:0] eye_in [3];
   logic signed [31:0] tgt_ff [3];
   logic signed [31:0] tgt_in [3];
   logic signed [31:0] up_ff  [3];
   logic signed [31:0] up_in  [3];

   logic signed [MO_W-1:0]  rxy_ff, rxy_in, dist_ff, dist_in, rad_ff, rad_in;
   logic signed [MO_W-1:0]  mex_ff, mex_in, mey_ff, mey_in, mez_ff, mez_in;
   logic signed [MO_W-1:0]  mux_ff, mux_in, muy_ff, muy_in;
   logic signed [ANG_W-1:0] az_ff, az_in, el_ff, el_in;
   logic signed [CW-1:0]    ca_ff, ca_in, sa_ff, sa_in, ce_ff, ce_in, se_ff, se_in;

   // Shared unit hookup
   logic                    cor_start, cor_rotate;
   logic signed [CW-1:0]    cor_x0, cor_y0, cor_x, cor_y;
   logic signed [ANG_W-1:0] cor_z;
   ocu_unit_status_type     cor_status;
   logic                    wrap_start;
   logic signed [ANG_W-1:0] wrap_angle, wrap_z;
   logic                    wrap_neg;
   ocu_unit_status_type     wrap_status;
   logic                    mul_start;
   logic signed [MA_W-1:0]  mul_a;
   logic signed [MB_W-1:0]  mul_b;
   logic signed [MO_W-1:0]  mul_p;
   ocu_unit_status_type     mul_status;

   logic signed [32:0]      diff_x, diff_y, diff_z;
   logic signed [ANG_W-1:0] ang;
   logic signed [MO_W:0]    zoom_sum;
   logic                    req_take, rsp_free;

   assign diff_x   = 33'(eye_ff[0]) - 33'(tgt_ff[0]);
   assign diff_y   = 33'(eye_ff[1]) - 33'(tgt_ff[1]);
   assign diff_z   = 33'(eye_ff[2]) - 33'(tgt_ff[2]);
   assign ang      = ANG_W'(req_ff.amount) <<< Q_SHIFT;
   assign zoom_sum = (MO_W+1)'(dist_ff) + (MO_W+1)'(req_ff.amount);
   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   ocu_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cor_start),
      .rotate (cor_rotate),
      .neg    (wrap_neg),
      .x0     (cor_x0),
      .y0     (cor_y0),
      .z0     (wrap_z),
      .x_out  (cor_x),
      .y_out  (cor_y),
      .z_out  (cor_z),
      .status (cor_status)
   );

   ocu_wrap u_wrap (
      .clock   (clock),
      .reset   (reset),
      .start   (wrap_start),
      .angle   (wrap_angle),
      .z_out   (wrap_z),
      .neg_out (wrap_neg),
      .status  (wrap_status)
   );

   ocu_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .p      (mul_p),
      .status (mul_status)
   );

   always_comb begin
      state_in     = state_ff;
      launched_in  = launched_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      req_in       = req_ff;
      eye_in       = eye_ff;
      tgt_in       = tgt_ff;
      up_in        = up_ff;
      rxy_in       = rxy_ff;
      dist_in      = dist_ff;
      rad_in       = rad_ff;
      mex_in       = mex_ff;
      mey_in       = mey_ff;
      mez_in       = mez_ff;
      mux_in       = mux_ff;
      muy_in       = muy_ff;
      az_in        = az_ff;
      el_in        = el_ff;
      ca_in        = ca_ff;
      sa_in        = sa_ff;
      ce_in        = ce_ff;
      se_in        = se_ff;
      cor_start    = 1'b0;
      cor_rotate   = 1'b0;
      cor_x0       = CW'(diff_x);
      cor_y0       = -CW'(diff_y);
      wrap_start   = 1'b0;
      wrap_angle   = az_ff;
      mul_start    = 1'b0;
      mul_a        = MA_W'(cor_x);
      mul_b        = MB_W'(KINV_A);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in = req_data;
               case (req_data.operation)
                  OP_SET_VIEW: begin
                     eye_in[0] = req_data.vec_a_x;
                     eye_in[1] = req_data.vec_a_y;
                     eye_in[2] = req_data.vec_a_z;
                     tgt_in[0] = req_data.vec_b_x;
                     tgt_in[1] = req_data.vec_b_y;
                     tgt_in[2] = req_data.vec_b_z;
                     up_in[0]  = req_data.vec_c_x;
                     up_in[1]  = req_data.vec_c_y;
                     up_in[2]  = req_data.vec_c_z;
                  end
                  OP_MOVE: begin
                     eye_in[0] = sat32((MO_W+1)'(eye_ff[0]) + (MO_W+1)'(req_data.vec_a_x));
                     eye_in[1] = sat32((MO_W+1)'(eye_ff[1]) + (MO_W+1)'(req_data.vec_a_y));
                     eye_in[2] = sat32((MO_W+1)'(eye_ff[2]) + (MO_W+1)'(req_data.vec_a_z));
                     tgt_in[0] = sat32((MO_W+1)'(tgt_ff[0]) + (MO_W+1)'(req_data.vec_a_x));
                     tgt_in[1] = sat32((MO_W+1)'(tgt_ff[1]) + (MO_W+1)'(req_data.vec_a_y));
                     tgt_in[2] = sat32((MO_W+1)'(tgt_ff[2]) + (MO_W+1)'(req_data.vec_a_z));
                  end
                  default: begin
                  end
               endcase
               final_in = !(req_data.operation == OP_ROT_EL ||
                            req_data.operation == OP_ROT_AZ ||
                            req_data.operation == OP_ZOOM);
               state_in = ST_VEC_A;
            end
         end
         ST_VEC_A: begin
            cor_start   = !launched_ff;
            launched_in = 1'b1;
            if (cor_status.done) begin
               az_in       = cor_z;
               launched_in = 1'b0;
               state_in    = ST_MAG_A;
            end
         end
         ST_MAG_A: begin
            mul_start   = !launched_ff;
            launched_in = 1'b1;
            if (mul_status.done) begin
               rxy_in      = mul_p;
               launched_in = 1'b0;
               state_in    = ST_VEC_B;
            end
         end
         ST_VEC_B: begin
            cor_x0      = rxy_ff[CW-1:0];
            cor_y0      = CW'(diff_z);
            cor_start   = !launched_ff;
            launched_in = 1'b1;
            if (cor_status.done) begin
               el_in       = cor_z;
               launched_in = 1'b0;
               state_in    = ST_MAG_B;
            end
         end
         ST_MAG_B: begin
            mul_start   = !launched_ff;
            launched_in = 1'b1;
            if (mul_status.done) begin
               dist_in     = mul_p;
               launched_in = 1'b0;
               state_in    = final_ff ? ST_FINISH : ST_APPLY;
            end
         end
         ST_APPLY: begin
            case (req_ff.operation)
               OP_ROT_EL: el_in = req_ff.absolute ? ang : el_ff + ang;
               OP_ROT_AZ: az_in = req_ff.absolute ? ang : az_ff + ang;
               default: begin
                  // Relative zoom only takes the sum while it stays positive.
                  if (req_ff.absolute) begin
                     dist_in = MO_W'(req_ff.amount);
                  end else if (zoom_sum > 0) begin
                     dist_in = zoom_sum[MO_W-1:0];
                  end
               end
            endcase
            state_in = ST_WRAP_AZ;
         end
         ST_WRAP_AZ: begin
            wrap_angle  = az_ff;
            wrap_start  = !launched_ff;
            launched_in = 1'b1;
            if (wrap_status.done) begin
               launched_in = 1'b0;
               state_in    = ST_ROT_AZ;
            end
         end
         ST_ROT_AZ: begin
            cor_rotate  = 1'b1;
            cor_start   = !launched_ff;
            launched_in = 1'b1;
            if (cor_status.done) begin
               ca_in       = cor_x;
               sa_in       = cor_y;
               launched_in = 1'b0;
               state_in    = ST_WRAP_EL;
            end
         end
         ST_WRAP_EL: begin
            wrap_angle  = el_ff;
            wrap_start  = !launched_ff;
            launched_in = 1'b1;
            if (wrap_status.done) begin
               launched_in = 1'b0;
               state_in    = ST_ROT_EL;
            end
         end
         ST_ROT_EL: begin
            cor_rotate  = 1'b1;
            cor_start   = !launched_ff;
            launched_in = 1'b1;
            if (cor_status.done) begin
               ce_in       = cor_x;
               se_in       = cor_y;
               launched_in = 1'b0;
               state_in    = ST_MUL_RAD;
            end
         end
         ST_MUL_RAD, ST_MUL_EX, ST_MUL_EY, ST_MUL_EZ, ST_MUL_UX, ST_MUL_UY: begin
            case (state_ff)
               ST_MUL_RAD: begin
                  mul_a = dist_ff[MA_W-1:0];
                  mul_b = ce_ff[MB_W-1:0];
               end
               ST_MUL_EX: begin
                  mul_a = rad_ff[MA_W-1:0];
                  mul_b = ca_ff[MB_W-1:0];
               end
               ST_MUL_EY: begin
                  mul_a = rad_ff[MA_W-1:0];
                  mul_b = sa_ff[MB_W-1:0];
               end
               ST_MUL_EZ: begin
                  mul_a = dist_ff[MA_W-1:0];
                  mul_b = se_ff[MB_W-1:0];
               end
               ST_MUL_UX: begin
                  mul_a = MA_W'(ca_ff);
                  mul_b = se_ff[MB_W-1:0];
               end
               default: begin
                  mul_a = MA_W'(sa_ff);
                  mul_b = se_ff[MB_W-1:0];
               end
            endcase
            mul_start   = !launched_ff;
            launched_in = 1'b1;
            if (mul_status.done) begin
               launched_in = 1'b0;
               case (state_ff)
                  ST_MUL_RAD: begin
                     rad_in   = mul_p;
                     state_in = ST_MUL_EX;
                  end
                  ST_MUL_EX: begin
                     mex_in   = mul_p;
                     state_in = ST_MUL_EY;
                  end
                  ST_MUL_EY: begin
                     mey_in   = mul_p;
                     state_in = ST_MUL_EZ;
                  end
                  ST_MUL_EZ: begin
                     mez_in   = mul_p;
                     state_in = ST_MUL_UX;
                  end
                  ST_MUL_UX: begin
                     mux_in   = mul_p;
                     state_in = ST_MUL_UY;
                  end
                  default: begin
                     muy_in   = mul_p;
                     state_in = ST_UPDATE;
                  end
               endcase
            end
         end
         ST_UPDATE: begin
            eye_in[0] = sat32((MO_W+1)'(tgt_ff[0]) + (MO_W+1)'(mex_ff));
            eye_in[1] = sat32((MO_W+1)'(tgt_ff[1]) - (MO_W+1)'(mey_ff));
            eye_in[2] = sat32((MO_W+1)'(tgt_ff[2]) + (MO_W+1)'(mez_ff));
            up_in[0]  = to_q(-mux_ff);
            up_in[1]  = to_q(muy_ff);
            up_in[2]  = to_q(MO_W'(ce_ff));
            final_in  = 1'b1;
            state_in  = ST_VEC_A;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_in.eye_out_x    = eye_ff[0];
               rsp_in.eye_out_y    = eye_ff[1];
               rsp_in.eye_out_z    = eye_ff[2];
               rsp_in.target_out_x = tgt_ff[0];
               rsp_in.target_out_y = tgt_ff[1];
               rsp_in.target_out_z = tgt_ff[2];
               rsp_in.up_out_x     = up_ff[0];
               rsp_in.up_out_y     = up_ff[1];
               rsp_in.up_out_z     = up_ff[2];
               if (dist_ff < 0) begin
                  rsp_in.distance_out = '0;
               end else if (dist_ff > MO_W'(64'sd2147483647)) begin
                  rsp_in.distance_out = '1;
               end else begin
                  rsp_in.distance_out = dist_ff[30:0];
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launched_ff  <= 1'b0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            eye_ff[k] <= '0;
            tgt_ff[k] <= '0;
            up_ff[k]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         launched_ff  <= launched_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
         eye_ff       <= eye_in;
         tgt_ff       <= tgt_in;
         up_ff        <= up_in;
      end
      rsp_ff  <= rsp_in;
      req_ff  <= req_in;
      rxy_ff  <= rxy_in;
      dist_ff <= dist_in;
      rad_ff  <= rad_in;
      mex_ff  <= mex_in;
      mey_ff  <= mey_in;
      mez_ff  <= mez_in;
      mux_ff  <= mux_in;
      muy_ff  <= muy_in;
      az_ff   <= az_in;
      el_ff   <= el_in;
      ca_ff   <= ca_in;
      sa_ff   <= sa_in;
      ce_ff   <= ce_in;
      se_ff   <= se_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Only one shared unit is ever at work.
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      $countones({cor_status.busy, wrap_status.busy, mul_status.busy}) <= 1)
      else $error("more than one shared unit busy");

   a_take_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_VEC_A)
      else $error("accepted transfer did not start the sequence");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result raised outside the finish step");

   a_idle_no_launch: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !launched_ff)
      else $error("unit launch left pending in idle");

endmodule
